/* design/shell_line_tokenizer_top_macros.svh */
// assertion macros for the line tokenizer
`ifndef SHELL_LINE_TOKENIZER_TOP_MACROS_SVH
`define SHELL_LINE_TOKENIZER_TOP_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off during reset
`define SLT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slt check failed");

// next-cycle implication, sampled on clk, off during reset
`define SLT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slt check failed");

`else

`define SLT_ASSERT_NOW(label, ante, cons)
`define SLT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* design/slt_pkg.sv */
`default_nettype none

package slt_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2,
		KIND_EOL  = 2'd3
	} kind_t;

	// lexer modes
	typedef enum logic [2:0] {
		M_IDLE     = 3'd0,
		M_BARE     = 3'd1,
		M_BARE_ESC = 3'd2,
		M_SQ       = 3'd3,
		M_DQ       = 3'd4,
		M_DQ_ESC   = 3'd5
	} mode_t;

	localparam logic [7:0] CH_DQ  = 8'h22;
	localparam logic [7:0] CH_SQ  = 8'h27;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR  = 8'h0D;

	// one result word
	typedef struct packed {
		kind_t      kind;
		logic [7:0] tok;
		logic       last;
	} res_t;

	// everything one input word produces
	typedef struct packed {
		logic [1:0] count;
		res_t [2:0] res;
		mode_t      next_mode;
	} lex_out_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

`default_nettype wire

/* design/slt_lexer.sv */
`default_nettype none

module slt_lexer (
	input  var slt_pkg::mode_t    mode,
	input  var logic [7:0]        ch,
	input  var logic              eol,
	output var slt_pkg::lex_out_t lex
);
	import slt_pkg::*;

	function automatic res_t mk(input kind_t k, input logic [7:0] c);
		res_t r;
		r.kind = k;
		r.tok  = (k == KIND_BYTE) ? c : 8'h00;
		r.last = 1'b0;
		return r;
	endfunction

	// one lexer step: result list and next mode
	always_comb begin
		lex           = '0;
		lex.next_mode = mode;
		if (eol) begin
			lex.next_mode = M_IDLE;
			unique case (mode)
				M_BARE, M_BARE_ESC: begin
					lex.res[0] = mk(KIND_END, 8'h00);
					lex.res[1] = mk(KIND_EOL, 8'h00);
					lex.count  = 2'd2;
				end
				M_SQ, M_DQ, M_DQ_ESC: begin
					lex.res[0] = mk(KIND_ERR, 8'h00);
					lex.res[1] = mk(KIND_EOL, 8'h00);
					lex.count  = 2'd2;
				end
				default: begin
					lex.res[0] = mk(KIND_EOL, 8'h00);
					lex.count  = 2'd1;
				end
			endcase
		end else begin
			unique case (mode)
				M_BARE: begin
					if (is_ws(ch)) begin
						lex.res[0]    = mk(KIND_END, 8'h00);
						lex.count     = 2'd1;
						lex.next_mode = M_IDLE;
					end else if (ch == CH_AMP) begin
						lex.res[0]    = mk(KIND_END, 8'h00);
						lex.res[1]    = mk(KIND_BYTE, ch);
						lex.res[2]    = mk(KIND_END, 8'h00);
						lex.count     = 2'd3;
						lex.next_mode = M_IDLE;
					end else begin
						lex.res[0] = mk(KIND_BYTE, ch);
						lex.count  = 2'd1;
						if (ch == CH_BSL)
							lex.next_mode = M_BARE_ESC;
					end
				end
				M_BARE_ESC: begin
					lex.res[0]    = mk(KIND_BYTE, ch);
					lex.count     = 2'd1;
					lex.next_mode = M_BARE;
				end
				M_SQ: begin
					lex.count = 2'd1;
					if (ch == CH_SQ) begin
						lex.res[0]    = mk(KIND_END, 8'h00);
						lex.next_mode = M_IDLE;
					end else begin
						lex.res[0] = mk(KIND_BYTE, ch);
					end
				end
				M_DQ: begin
					lex.count = 2'd1;
					if (ch == CH_DQ) begin
						lex.res[0]    = mk(KIND_END, 8'h00);
						lex.next_mode = M_IDLE;
					end else begin
						lex.res[0] = mk(KIND_BYTE, ch);
						if (ch == CH_BSL)
							lex.next_mode = M_DQ_ESC;
					end
				end
				M_DQ_ESC: begin
					lex.res[0]    = mk(KIND_BYTE, ch);
					lex.count     = 2'd1;
					lex.next_mode = (ch == CH_BSL) ? M_DQ_ESC : M_DQ;
				end
				default: begin
					// between tokens
					if (is_ws(ch)) begin
						lex.count = 2'd0;
					end else if (ch == CH_AMP) begin
						lex.res[0] = mk(KIND_BYTE, ch);
						lex.res[1] = mk(KIND_END, 8'h00);
						lex.count  = 2'd2;
					end else if (ch == CH_DQ) begin
						lex.next_mode = M_DQ;
					end else if (ch == CH_SQ) begin
						lex.next_mode = M_SQ;
					end else begin
						lex.res[0]    = mk(KIND_BYTE, ch);
						lex.count     = 2'd1;
						lex.next_mode = (ch == CH_BSL) ? M_BARE_ESC : M_BARE;
					end
				end
			endcase
		end

		// mark the final result of this word
		unique case (lex.count)
			2'd1:    lex.res[0].last = 1'b1;
			2'd2:    lex.res[1].last = 1'b1;
			2'd3:    lex.res[2].last = 1'b1;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* design/slt_emit.sv */
`default_nettype none

module slt_emit (
	input  var logic              clk,
	input  var logic              arst_n,
	input  var logic              item_valid,
	input  var slt_pkg::lex_out_t lex,
	output var logic              done,
	output var logic              m_tvalid,
	input  var logic              m_tready,
	output var logic [7:0]        m_tdata,   // token_byte [7:0]
	output var logic [1:0]        m_tuser,   // kind [1:0]
	output var logic              m_tlast
);
	import slt_pkg::*;

	logic [1:0] idx_q;
	logic       valid_s2;
	res_t       res_s2;
	res_t       sel;
	logic       s2_free;
	logic       load;
	logic       at_final;

	// pick the next result of the current word
	always_comb begin
		unique case (idx_q)
			2'd0:    sel = lex.res[0];
			2'd1:    sel = lex.res[1];
			default: sel = lex.res[2];
		endcase
	end

	assign s2_free  = !valid_s2 || m_tready;
	assign load     = item_valid && (lex.count != 2'd0) && s2_free;
	assign at_final = (idx_q == (lex.count - 2'd1));
	assign done     = item_valid && ((lex.count == 2'd0) || (s2_free && at_final));

	// result index within the current word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (done) begin
			idx_q <= 2'd0;
		end else if (load) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_s2 <= sel;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2.tok;
	assign m_tuser  = res_s2.kind;
	assign m_tlast  = res_s2.last;

endmodule

`default_nettype wire

/* design/shell_line_tokenizer_top.sv */
// Command-line tokenizer.
// Input stream s_*: one character per word in s_tdata; a word with s_tlast
// high marks end of line and its data is ignored.
// Output stream m_*: one result per word. m_tuser gives the kind (token byte,
// end of token, unmatched quote error, end of line), m_tdata the byte for
// token bytes and zero otherwise, m_tlast flags the final result of an
// input word. Whitespace between tokens and opening quotes give no result.
// A result passes through the input register, then the output register. An
// input word producing k results holds the input register until all k are
// loaded (k is at most three, for '&' ending a bare word), so with m_tready
// high, plain characters stream at one word per cycle and results are loaded
// one per cycle into a single output register, which sets the rate.
// A stalled receiver holds the output register, then the input register,
// and s_tready drops; nothing is lost or repeated.
// Reset clears the valid flags of both registers and returns the lexer to between tokens.
`default_nettype none
`include "shell_line_tokenizer_top_macros.svh"

module shell_line_tokenizer_top (
	input  var logic       clk,
	input  var logic       arst_n,
	input  var logic       s_tvalid,
	output var logic       s_tready,
	input  var logic [7:0] s_tdata,   // ch [7:0]
	input  var logic       s_tlast,
	output var logic       m_tvalid,
	input  var logic       m_tready,
	output var logic [7:0] m_tdata,   // token_byte [7:0]
	output var logic [1:0] m_tuser,   // kind [1:0]
	output var logic       m_tlast
);
	import slt_pkg::*;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       eol_s1;
	mode_t      mode_q;
	lex_out_t   lex;
	logic       done;

	assign s_tready = !valid_s1 || done;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1  <= s_tdata;
			eol_s1 <= s_tlast;
		end
	end

	// lexer mode advances when a word has sent all its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
		end else if (done) begin
			mode_q <= lex.next_mode;
		end
	end

	slt_lexer u_lexer (
		.mode (mode_q),
		.ch   (ch_s1),
		.eol  (eol_s1),
		.lex  (lex)
	);

	slt_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.lex        (lex),
		.done       (done),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	// checks
	`SLT_ASSERT_NOW(a_eol_is_last, m_tvalid && (m_tuser == KIND_EOL), m_tlast)
	`SLT_ASSERT_NOW(a_mark_no_byte, m_tvalid && (m_tuser != KIND_BYTE), m_tdata == 8'h00)
	`SLT_ASSERT_NEXT(a_eol_to_idle, done && eol_s1, mode_q == M_IDLE)
	`SLT_ASSERT_NEXT(a_word_held, valid_s1 && !done, valid_s1 && $stable(ch_s1))

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import slt_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int WORD_TARGET = 435;
	localparam res_t NO_RES = '0;

	// one row of the directed script; typed rows carry their own results
	typedef struct packed {
		logic [7:0] ch;
		logic       eol;
		logic       typed;
		logic [1:0] n;
		res_t [2:0] r;
	} line_row_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // ch [7:0]
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // token_byte [7:0]
	logic [1:0] m_tuser;   // kind [1:0]
	logic       m_tlast;

	mode_t     lex_state;
	res_t      expected_tokens[$];
	line_row_t script[$];
	logic      calm;
	int        errors;
	int        quiet_cycles;
	int        words_sent;
	int        busy_words;
	int        lines_sent;
	int        kind_seen[4];

	shell_line_tokenizer_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic res_t res_word(input kind_t k, input logic [7:0] b);
		res_t w;
		w.kind = k;
		w.tok  = (k == KIND_BYTE) ? b : 8'h00;
		w.last = 1'b0;
		return w;
	endfunction

	// expected results of one character or line end, advancing the lexer state
	function automatic int tokenize_char(input logic [7:0] c, input logic eol,
			output res_t [2:0] r);
		int    n;
		mode_t m;
		n = 0;
		r = '0;
		m = lex_state;
		if (eol) begin
			if (m == M_BARE || m == M_BARE_ESC) begin
				r[n] = res_word(KIND_END, 8'h00);
				n++;
			end else if (m == M_SQ || m == M_DQ || m == M_DQ_ESC) begin
				r[n] = res_word(KIND_ERR, 8'h00);
				n++;
			end
			r[n] = res_word(KIND_EOL, 8'h00);
			n++;
			m = M_IDLE;
		end else begin
			case (m)
				M_BARE: begin
					if (is_blank(c)) begin
						r[n] = res_word(KIND_END, 8'h00);
						n++;
						m = M_IDLE;
					end else if (c == CH_AMP) begin
						r[0] = res_word(KIND_END, 8'h00);
						r[1] = res_word(KIND_BYTE, c);
						r[2] = res_word(KIND_END, 8'h00);
						n = 3;
						m = M_IDLE;
					end else begin
						r[n] = res_word(KIND_BYTE, c);
						n++;
						if (c == CH_BSL)
							m = M_BARE_ESC;
					end
				end
				M_BARE_ESC: begin
					r[n] = res_word(KIND_BYTE, c);
					n++;
					m = M_BARE;
				end
				M_SQ: begin
					r[n] = (c == CH_SQ) ? res_word(KIND_END, 8'h00) : res_word(KIND_BYTE, c);
					n++;
					if (c == CH_SQ)
						m = M_IDLE;
				end
				M_DQ: begin
					r[n] = (c == CH_DQ) ? res_word(KIND_END, 8'h00) : res_word(KIND_BYTE, c);
					n++;
					if (c == CH_DQ)
						m = M_IDLE;
					else if (c == CH_BSL)
						m = M_DQ_ESC;
				end
				M_DQ_ESC: begin
					// a backslash run keeps the next quote literal
					r[n] = res_word(KIND_BYTE, c);
					n++;
					m = (c == CH_BSL) ? M_DQ_ESC : M_DQ;
				end
				default: begin
					// between tokens
					if (is_blank(c)) begin
					end else if (c == CH_AMP) begin
						r[0] = res_word(KIND_BYTE, c);
						r[1] = res_word(KIND_END, 8'h00);
						n = 2;
					end else if (c == CH_DQ) begin
						m = M_DQ;
					end else if (c == CH_SQ) begin
						m = M_SQ;
					end else begin
						r[n] = res_word(KIND_BYTE, c);
						n++;
						m = (c == CH_BSL) ? M_BARE_ESC : M_BARE;
					end
				end
			endcase
		end
		lex_state = m;
		if (n > 0)
			r[n - 1].last = 1'b1;
		return n;
	endfunction

	function automatic line_row_t plain_row(input logic [7:0] c, input logic eol);
		line_row_t row;
		row = '0;
		row.ch  = c;
		row.eol = eol;
		return row;
	endfunction

	function automatic line_row_t fixed_row(input logic [7:0] c, input logic eol,
			input logic [1:0] n, input res_t a, input res_t b, input res_t d);
		line_row_t row;
		row = plain_row(c, eol);
		row.typed = 1'b1;
		row.n     = n;
		row.r[0]  = a;
		row.r[1]  = b;
		row.r[2]  = d;
		if (n > 0)
			row.r[n - 1].last = 1'b1;
		return row;
	endfunction

	// drive one word at the falling edge, wait for its handshake, queue its results
	task automatic send_word(input line_row_t row);
		int         gap;
		int         n;
		res_t [2:0] r;
		mode_t      prev;
		gap = 0;
		if (!calm && $urandom_range(99) < 8)
			gap = $urandom_range(1, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= row.ch;
		s_tlast  <= row.eol;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		prev = lex_state;
		n = tokenize_char(row.ch, row.eol, r);
		if (row.typed) begin
			n = int'(row.n);
			r = row.r;
		end
		for (int i = 0; i < n; i++)
			expected_tokens.push_back(r[i]);
		words_sent++;
		if (n > 0 || lex_state != prev)
			busy_words++;
		@(negedge clk);
	endtask

	task automatic put(input logic [7:0] c);
		send_word(plain_row(c, 1'b0));
	endtask

	function automatic logic [7:0] pick_blank();
		int v;
		v = $urandom_range(8, 13);
		return (v == 8) ? CH_SP : 8'(v);
	endfunction

	// bare word of random bytes, with escapes and an occasional trailing ampersand
	task automatic bare_word();
		int         len;
		logic [7:0] c;
		len = $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 10) begin
				put(CH_BSL);
				put(8'($urandom_range(0, 255)));
			end else if (i > 0 && $urandom_range(99) < 6) begin
				put(CH_AMP);
				break;
			end else begin
				c = 8'($urandom_range(0, 255));
				while (is_blank(c) || (i == 0 && (c == CH_DQ || c == CH_SQ || c == CH_AMP)))
					c = 8'($urandom_range(0, 255));
				put(c);
			end
		end
	endtask

	// quoted string with random content, closed or left open
	task automatic quoted(input logic dq, input logic close);
		int         len;
		logic [7:0] c;
		logic       prev_bsl;
		len = $urandom_range(0, 6);
		prev_bsl = 1'b0;
		put(dq ? CH_DQ : CH_SQ);
		for (int i = 0; i < len; i++) begin
			c = 8'($urandom_range(0, 255));
			if ($urandom_range(7) == 0)
				c = CH_BSL;
			if (!dq && c == CH_SQ)
				c = CH_BSL;
			if (dq && c == CH_DQ && !prev_bsl)
				put(CH_BSL);
			put(c);
			prev_bsl = (c == CH_BSL);
		end
		if (close) begin
			// a trailing backslash would swallow the closing quote
			if (dq && prev_bsl)
				put(8'h7A);
			put(dq ? CH_DQ : CH_SQ);
		end
	endtask

	// one command line: tokens separated by whitespace, sometimes an unclosed quote, then the line end
	task automatic send_line();
		int ntok;
		int sel;
		ntok = $urandom_range(0, 5);
		if ($urandom_range(3) == 0)
			put(pick_blank());
		for (int t = 0; t < ntok; t++) begin
			sel = $urandom_range(0, 11);
			if (sel <= 4)
				bare_word();
			else if (sel <= 6)
				quoted(1'b0, 1'b1);
			else if (sel <= 8)
				quoted(1'b1, 1'b1);
			else if (sel == 9)
				put(CH_AMP);
			else
				repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
			repeat ($urandom_range(1, 2)) put(pick_blank());
		end
		if ($urandom_range(9) == 0)
			quoted(1'($urandom_range(1)), 1'b0);
		send_word(plain_row(8'($urandom_range(0, 255)), 1'b1));
		lines_sent++;
	endtask

	// receiver back-pressure
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= calm || ($urandom_range(99) >= 8);
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected result: kind %0d, token_byte %02h, last %0b",
					m_tuser, m_tdata, m_tlast);
				errors++;
			end else begin
				want = expected_tokens.pop_front();
				kind_seen[want.kind]++;
				if (m_tuser !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, m_tuser);
					errors++;
				end
				if (m_tdata !== want.tok) begin
					$error("token_byte: expected %02h, got %02h", want.tok, m_tdata);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tlast      = 1'b0;
		m_tready     = 1'b0;
		calm         = 1'b0;
		errors       = 0;
		quiet_cycles = 0;
		words_sent   = 0;
		busy_words   = 0;
		lines_sent   = 0;
		kind_seen    = '{default: 0};
		lex_state    = M_IDLE;

		// directed script: extremes, every mode, escapes and each kind of line end
		script.push_back(fixed_row(8'hFF, 1'b1, 2'd1, res_word(KIND_EOL, 8'h00), NO_RES, NO_RES));
		script.push_back(fixed_row(CH_SP, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES));
		script.push_back(fixed_row(CH_AMP, 1'b0, 2'd2, res_word(KIND_BYTE, CH_AMP),
			res_word(KIND_END, 8'h00), NO_RES));
		script.push_back(plain_row(8'h61, 1'b0));
		script.push_back(plain_row(8'hFF, 1'b0));
		script.push_back(plain_row(CH_BSL, 1'b0));
		script.push_back(plain_row(CH_SP, 1'b0));
		script.push_back(plain_row(CH_DQ, 1'b0));
		script.push_back(fixed_row(CH_AMP, 1'b0, 2'd3, res_word(KIND_END, 8'h00),
			res_word(KIND_BYTE, CH_AMP), res_word(KIND_END, 8'h00)));
		script.push_back(plain_row(8'h00, 1'b0));
		script.push_back(plain_row(CH_CR, 1'b0));
		script.push_back(plain_row(CH_SQ, 1'b0));
		script.push_back(plain_row(CH_SQ, 1'b0));
		script.push_back(plain_row(CH_DQ, 1'b0));
		script.push_back(plain_row(CH_DQ, 1'b0));
		script.push_back(plain_row(CH_DQ, 1'b0));
		script.push_back(plain_row(CH_BSL, 1'b0));
		script.push_back(plain_row(CH_BSL, 1'b0));
		script.push_back(plain_row(CH_DQ, 1'b0));
		script.push_back(plain_row(CH_DQ, 1'b0));
		script.push_back(plain_row(8'h78, 1'b0));
		script.push_back(plain_row(8'h00, 1'b1));
		script.push_back(plain_row(CH_SQ, 1'b0));
		script.push_back(plain_row(8'h79, 1'b0));
		script.push_back(fixed_row(8'h00, 1'b1, 2'd2, res_word(KIND_ERR, 8'h00),
			res_word(KIND_EOL, 8'h00), NO_RES));
		script.push_back(plain_row(CH_TAB, 1'b0));
		script.push_back(fixed_row(8'hAA, 1'b1, 2'd1, res_word(KIND_EOL, 8'h00), NO_RES, NO_RES));

		// hold reset, then release it on a falling edge
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i])
			send_word(script[i]);

		// random lines, with a stretch of full-rate traffic on both sides
		while (words_sent < WORD_TARGET + script.size()) begin
			calm = (lines_sent >= 15 && lines_sent < 30);
			send_line();
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// drain, then wait for anything stray
		while (expected_tokens.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d input words (%0d with output or a mode change) in %0d lines",
			words_sent, busy_words, lines_sent);
		$display("checked %0d token bytes, %0d token ends, %0d quote errors, %0d line ends",
			kind_seen[KIND_BYTE], kind_seen[KIND_END], kind_seen[KIND_ERR], kind_seen[KIND_EOL]);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
